@@ hdl/pwls_pkg.sv @@
package pwls_pkg;

  // Number of ADC samples taken while one probe is driven (1 to 15).
  localparam int unsigned SAMPLES = 10;

  localparam int unsigned WAIT_W   = 16;
  localparam int unsigned ADC_W    = 10;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned DRIVE_W  = 4;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WET_THRESHOLD = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [WAIT_W-1:0] WAIT_TICKS_RST    = 16'd100;
  localparam logic [ADC_W-1:0]  WET_THRESHOLD_RST = 10'd34;

  // Command codes.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // Level codes.
  localparam logic [LEVEL_W-1:0] LVL_UNSET = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_DRY   = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_AT10  = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_AT30  = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_AT70  = 3'd4;
  localparam logic [LEVEL_W-1:0] LVL_AT100 = 3'd5;

  // Probe drive patterns.
  localparam logic [DRIVE_W-1:0] DRIVE_NONE = 4'b0000;
  localparam logic [DRIVE_W-1:0] DRIVE_100  = 4'b1000;
  localparam logic [DRIVE_W-1:0] DRIVE_70   = 4'b0100;
  localparam logic [DRIVE_W-1:0] DRIVE_30   = 4'b0010;
  localparam logic [DRIVE_W-1:0] DRIVE_10   = 4'b0001;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_INIT  = 4'd1,
    PH_EN100 = 4'd2,
    PH_MS100 = 4'd3,
    PH_EN70  = 4'd4,
    PH_MS70  = 4'd5,
    PH_EN30  = 4'd6,
    PH_MS30  = 4'd7,
    PH_EN10  = 4'd8,
    PH_MS10  = 4'd9,
    PH_CLEAN = 4'd10
  } phase_t;

  typedef struct packed {
    logic             func;
    logic [ADC_W-1:0] adc_sample;
  } cmd_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] probe_drive;
    logic [LEVEL_W-1:0] level_code;
    logic               busy_res;
    logic               start_rejected;
  } res_t;

endpackage

@@ hdl/probe_water_level_sequencer.sv @@
// Probe water level sequencer.
//
// Command channel (cmd_valid, cmd_stall, cmd): each transaction is either a
// tick (one pass of the control loop, one millisecond) carrying the current
// ADC code, or a start command. Result channel (res_valid, res_stall, res):
// exactly one result transaction follows every command transaction, in order,
// showing the probe drive, the level code, the busy flag and whether a start
// was refused because a measurement was already running.
// Configuration: cfg_we writes cfg_data into the register chosen by cfg_index
// (0 = wait_ticks, 1 = wet_threshold); other indexes are ignored. Write only
// while the block is idle.
//
// A command is accepted into an input register, then the sequencer state and
// the result register are updated from it on the edge on which the result
// side is free. One command per cycle is sustained while the receiver does
// not stall; the only loop is the state update. When the receiver stalls,
// the result register holds its contents and the input register absorbs one
// more command before cmd_stall rises. Reset (rst, synchronous) empties both
// registers, releases all probes, sets the level to unknown and restores the
// configuration defaults.
module probe_water_level_sequencer
  import pwls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_t                 cmd,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [WAIT_W-1:0] wait_ticks;
  logic [ADC_W-1:0]  wet_threshold;

  // Input register.
  logic s1_valid;
  cmd_t s1_cmd;

  // Sequencer state and its next values.
  phase_t             phase, phase_next;
  logic [WAIT_W-1:0]  since_sample, since_sample_next;
  logic [CNT_W-1:0]   sample_count, sample_count_next;
  logic [ADC_W-1:0]   peak_code, peak_code_next;
  logic [LEVEL_W-1:0] level_result, level_result_next;
  logic [DRIVE_W-1:0] drive_bits, drive_bits_next;
  logic               rejected_next;

  logic               res_free;
  logic               s1_fire;
  logic               cmd_take;

  // Working values for a measure tick.
  logic               measuring;
  logic [LEVEL_W-1:0] probe_level;
  logic [WAIT_W-1:0]  elapsed;
  logic               take_sample;
  logic [ADC_W-1:0]   peak_new;
  logic [CNT_W-1:0]   count_new;

  assign res_free  = !res_valid || !res_stall;
  assign s1_fire   = s1_valid && res_free;
  assign cmd_stall = s1_valid && !res_free;
  assign cmd_take  = cmd_valid && !cmd_stall;

  // Level that a measure phase records if its probe is wet.
  always_comb begin
    measuring   = 1'b1;
    probe_level = LVL_UNSET;
    case (phase)
      PH_MS100: probe_level = LVL_AT100;
      PH_MS70:  probe_level = LVL_AT70;
      PH_MS30:  probe_level = LVL_AT30;
      PH_MS10:  probe_level = LVL_AT10;
      default:  measuring   = 1'b0;
    endcase
  end

  // The counter since the last sample saturates rather than wrapping.
  assign elapsed     = (&since_sample) ? since_sample : since_sample + 1'b1;
  assign take_sample = (sample_count < CNT_W'(SAMPLES)) && (elapsed >= wait_ticks);
  assign peak_new    = (take_sample && (s1_cmd.adc_sample > peak_code)) ?
                       s1_cmd.adc_sample : peak_code;
  assign count_new   = take_sample ? sample_count + 1'b1 : sample_count;

  always_comb begin
    phase_next        = phase;
    since_sample_next = since_sample;
    sample_count_next = sample_count;
    peak_code_next    = peak_code;
    level_result_next = level_result;
    drive_bits_next   = drive_bits;
    rejected_next     = 1'b0;

    if (s1_cmd.func == FUNC_START) begin
      if (phase == PH_IDLE) begin
        phase_next = PH_INIT;
      end else begin
        rejected_next = 1'b1;
      end
    end else if (measuring) begin
      since_sample_next = take_sample ? '0 : elapsed;
      peak_code_next    = peak_new;
      sample_count_next = count_new;
      if (count_new == CNT_W'(SAMPLES)) begin
        sample_count_next = '0;
        if (peak_new > wet_threshold) begin
          level_result_next = probe_level;
          phase_next        = PH_CLEAN;
        end else begin
          if (phase == PH_MS10) begin
            level_result_next = LVL_DRY;
          end
          phase_next = phase_t'(phase + 4'd1);
        end
      end
    end else begin
      case (phase)
        PH_IDLE: begin
        end
        PH_INIT: begin
          since_sample_next = '0;
          sample_count_next = '0;
          peak_code_next    = '0;
          level_result_next = LVL_UNSET;
          phase_next        = PH_EN100;
        end
        PH_EN100: begin
          drive_bits_next   = DRIVE_100;
          since_sample_next = '0;
          phase_next        = PH_MS100;
        end
        PH_EN70: begin
          drive_bits_next   = DRIVE_70;
          since_sample_next = '0;
          phase_next        = PH_MS70;
        end
        PH_EN30: begin
          drive_bits_next   = DRIVE_30;
          since_sample_next = '0;
          phase_next        = PH_MS30;
        end
        PH_EN10: begin
          drive_bits_next   = DRIVE_10;
          since_sample_next = '0;
          phase_next        = PH_MS10;
        end
        PH_CLEAN: begin
          drive_bits_next = DRIVE_NONE;
          phase_next      = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Control and sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      res_valid     <= 1'b0;
      wait_ticks    <= WAIT_TICKS_RST;
      wet_threshold <= WET_THRESHOLD_RST;
      phase         <= PH_IDLE;
      since_sample  <= '0;
      sample_count  <= '0;
      peak_code     <= '0;
      level_result  <= LVL_UNSET;
      drive_bits    <= DRIVE_NONE;
    end else begin
      if (cmd_take) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_WAIT_TICKS:    wait_ticks    <= cfg_data[WAIT_W-1:0];
          REG_WET_THRESHOLD: wet_threshold <= cfg_data[ADC_W-1:0];
          default: begin
          end
        endcase
      end

      if (s1_fire) begin
        phase        <= phase_next;
        since_sample <= since_sample_next;
        sample_count <= sample_count_next;
        peak_code    <= peak_code_next;
        level_result <= level_result_next;
        drive_bits   <= drive_bits_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s1_cmd <= cmd;
    end
    if (s1_fire) begin
      res.probe_drive    <= drive_bits_next;
      res.level_code     <= level_result_next;
      res.busy_res       <= (phase_next != PH_IDLE);
      res.start_rejected <= rejected_next;
    end
  end

  // A refused start can only be reported while a measurement is running.
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.start_rejected |-> res.busy_res)
    else $error("start refused while idle");

  // All probes are released whenever the sequencer is idle.
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (drive_bits == DRIVE_NONE))
    else $error("probe driven while idle");

  // At most one probe is driven at a time.
  a_one_probe: assert property (@(posedge clk) disable iff (rst)
    $onehot0(drive_bits))
    else $error("more than one probe driven");

  // The sample counter never passes the sample count.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(SAMPLES))
    else $error("sample counter out of range");

  // A command left in the input register is processed once the result side frees.
  a_stage_drains: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res_free |=> res_valid)
    else $error("input register did not produce a result");

endmodule
